[design/ac3rtp_pkg.sv]
// Shared types and constants for the AC-3 RTP fragmenter.
package ac3rtp_pkg;

    // Field widths
    localparam int LEN_W   = 13;
    localparam int TS_W    = 32;
    localparam int MTU_W   = 14;
    localparam int ROOM_W  = 14;
    localparam int CNT_W   = 7;
    localparam int TYPE_W  = 2;

    // Stream data widths (packed fields, padded to whole bytes)
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 72;

    // MTU limits and header size
    localparam logic [MTU_W-1:0] MTU_RESET = 14'd1436;
    localparam logic [MTU_W-1:0] MTU_MIN   = 14'd130;
    localparam logic [MTU_W-1:0] MTU_MAX   = 14'd9216;
    localparam logic [MTU_W-1:0] HDR_BYTES = 14'd2;
    localparam int               LEN_MAX   = 8191;

    // RFC 4184 frame type codes
    localparam logic [TYPE_W-1:0] FT_WHOLE = 2'd0;
    localparam logic [TYPE_W-1:0] FT_FIRST_MAJOR = 2'd1;
    localparam logic [TYPE_W-1:0] FT_FIRST_MINOR = 2'd2;
    localparam logic [TYPE_W-1:0] FT_CONT = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_CLASSIFY,
        ST_EMIT
    } state_t;

    // Sequencer control strobes
    typedef struct packed {
        logic load_item;
        logic count_step;
        logic classify;
        logic emit_step;
    } ctl_t;

endpackage

[design/ac3_rtp_fragmenter.sv]
// Top level of the AC-3 RTP fragmenter: frame descriptor in, packet descriptors out.
//
//  Channel   Direction  Signals                        Contents
//  s_axis    in         s_tvalid/s_tready/s_tdata      frame_length, frame_timestamp
//  m_axis    out        m_tvalid/m_tready/m_tdata      type, count, offset, length, timestamp
//                       m_tlast                        last packet of the frame (RTP marker)
//  cfg       in         cfg_valid/cfg_ready/cfg_data   mtu_limit
//
// A frame passes through an accept step, a count loop, a classify step and an emit loop
// that issues its C packets, where C is the packet count (1..64); the count loop and the emit loop share one
// subtract-and-compare unit against the payload room. The output register lets the
// next frame be accepted and counted while the last packet still waits.
// Reset clears the sequencer, the output valid and sets the MTU limit to 1436.
// A stall on m_tready holds the emit loop; configuration is always accepted.
module ac3_rtp_fragmenter #(
    parameter int MAX_FRAGMENTS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // s_tdata: [12:0] frame_length, [44:13] frame_timestamp, [47:45] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ac3rtp_pkg::S_DATA_W-1:0]   s_tdata,
    // m_tdata: [1:0] frame_type, [8:2] fragment_count, [21:9] payload_offset,
    //          [34:22] payload_length, [66:35] packet_timestamp, [71:67] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ac3rtp_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ac3rtp_pkg::MTU_W-1:0]      cfg_data
);

    localparam int LEN_W  = ac3rtp_pkg::LEN_W;
    localparam int TS_W   = ac3rtp_pkg::TS_W;
    localparam int ROOM_W = ac3rtp_pkg::ROOM_W;
    localparam int CNT_W  = ac3rtp_pkg::CNT_W;
    localparam int TYPE_W = ac3rtp_pkg::TYPE_W;
    localparam int MIN_ROOM_I = (ac3rtp_pkg::LEN_MAX + MAX_FRAGMENTS - 1) / MAX_FRAGMENTS;
    localparam logic [ROOM_W-1:0] MIN_ROOM = ROOM_W'(MIN_ROOM_I);
    localparam int PAD_W = ac3rtp_pkg::M_DATA_W - (TYPE_W + CNT_W + 2 * LEN_W + TS_W);

    ac3rtp_pkg::state_t state_reg, state_next;
    ac3rtp_pkg::ctl_t   ctl;

    logic [ac3rtp_pkg::MTU_W-1:0] mtu_reg;
    logic [ROOM_W-1:0]            room_reg;
    logic [LEN_W-1:0]             len_reg;
    logic [TS_W-1:0]              ts_reg;
    logic [LEN_W-1:0]             rem_reg;
    logic [LEN_W-1:0]             offset_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [TYPE_W-1:0]            ftype_reg;
    logic                         first_reg;

    logic                         out_valid_reg;
    logic [TYPE_W-1:0]            out_type_reg;
    logic [CNT_W-1:0]             out_cnt_reg;
    logic [LEN_W-1:0]             out_off_reg;
    logic [LEN_W-1:0]             out_len_reg;
    logic [TS_W-1:0]              out_ts_reg;
    logic                         out_last_reg;

    logic [ac3rtp_pkg::MTU_W-1:0] mtu_clamp;
    logic [ROOM_W-1:0]            room_raw;
    logic [ROOM_W-1:0]            room_calc;
    logic                         rem_gt;
    logic [LEN_W-1:0]             rem_diff;
    logic [LEN_W-1:0]             chunk;
    logic [16:0]                  five_len;
    logic [16:0]                  eight_room;
    logic                         out_free;
    logic                         s_fire;

    // Clamp the MTU and derive the payload room
    always_comb
    begin
        if (mtu_reg < ac3rtp_pkg::MTU_MIN)
            mtu_clamp = ac3rtp_pkg::MTU_MIN;
        else if (mtu_reg > ac3rtp_pkg::MTU_MAX)
            mtu_clamp = ac3rtp_pkg::MTU_MAX;
        else
            mtu_clamp = mtu_reg;
        room_raw  = mtu_clamp - ac3rtp_pkg::HDR_BYTES;
        room_calc = (room_raw < MIN_ROOM) ? MIN_ROOM : room_raw;
    end

    // Shared unit: compare and subtract the remainder against the room
    assign rem_gt   = {1'b0, rem_reg} > room_reg;
    assign rem_diff = LEN_W'({1'b0, rem_reg} - room_reg);
    assign chunk    = rem_gt ? LEN_W'(room_reg) : rem_reg;

    // Five eighths test terms
    assign five_len   = {2'b00, len_reg, 2'b00} + {4'b0000, len_reg};
    assign eight_room = {room_reg, 3'b000};

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ac3rtp_pkg::ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ac3rtp_pkg::ST_IDLE:
            begin
                if (s_fire)
                    state_next = ac3rtp_pkg::ST_COUNT;
            end
            ac3rtp_pkg::ST_COUNT:
            begin
                if (!rem_gt)
                    state_next = ac3rtp_pkg::ST_CLASSIFY;
            end
            ac3rtp_pkg::ST_CLASSIFY:
            begin
                state_next = ac3rtp_pkg::ST_EMIT;
            end
            ac3rtp_pkg::ST_EMIT:
            begin
                if (out_free && !rem_gt)
                    state_next = ac3rtp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ac3rtp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control strobes
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ac3rtp_pkg::ST_IDLE:     ctl.load_item  = s_fire;
            ac3rtp_pkg::ST_COUNT:    ctl.count_step = rem_gt;
            ac3rtp_pkg::ST_CLASSIFY: ctl.classify   = 1'b1;
            ac3rtp_pkg::ST_EMIT:     ctl.emit_step  = out_free;
            default:                 ctl = '0;
        endcase
    end

    // Sequencer and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ac3rtp_pkg::ST_IDLE;
            mtu_reg       <= ac3rtp_pkg::MTU_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                mtu_reg <= cfg_data;
            if (ctl.emit_step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath: latch, count, classify, emit
    always_ff @(posedge clk)
    begin
        if (ctl.load_item)
        begin
            len_reg  <= s_tdata[LEN_W-1:0];
            rem_reg  <= s_tdata[LEN_W-1:0];
            ts_reg   <= s_tdata[LEN_W+TS_W-1:LEN_W];
            room_reg <= room_calc;
            cnt_reg  <= CNT_W'(1);
        end
        if (ctl.count_step)
        begin
            rem_reg <= rem_diff;
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
        if (ctl.classify)
        begin
            rem_reg    <= len_reg;
            offset_reg <= '0;
            first_reg  <= 1'b1;
            if (cnt_reg == CNT_W'(1))
                ftype_reg <= ac3rtp_pkg::FT_WHOLE;
            else if (five_len <= eight_room)
                ftype_reg <= ac3rtp_pkg::FT_FIRST_MAJOR;
            else
                ftype_reg <= ac3rtp_pkg::FT_FIRST_MINOR;
        end
        if (ctl.emit_step)
        begin
            out_type_reg <= first_reg ? ftype_reg : ac3rtp_pkg::FT_CONT;
            out_cnt_reg  <= cnt_reg;
            out_off_reg  <= offset_reg;
            out_len_reg  <= chunk;
            out_ts_reg   <= ts_reg;
            out_last_reg <= !rem_gt;
            rem_reg      <= rem_gt ? rem_diff : '0;
            offset_reg   <= offset_reg + chunk;
            first_reg    <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_ts_reg, out_len_reg, out_off_reg,
                       out_cnt_reg, out_type_reg};

endmodule

[design/ac3rtp_checker.sv]
// Port-level checker for the AC-3 RTP fragmenter, bound to the top level.
module ac3rtp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ac3rtp_pkg::M_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    logic [ac3rtp_pkg::TYPE_W-1:0] ftype;
    logic [ac3rtp_pkg::CNT_W-1:0]  fcount;
    logic [ac3rtp_pkg::LEN_W-1:0]  foffset;

    assign ftype   = m_tdata[1:0];
    assign fcount  = m_tdata[8:2];
    assign foffset = m_tdata[21:9];

    // Hold a stalled transaction
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    // Whole frame is a single, final packet
    a_whole: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ftype == ac3rtp_pkg::FT_WHOLE |-> m_tlast && fcount == 7'd1)
        else $error("whole frame packet not single and last");

    // First fragment starts the frame and is never last
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (ftype == ac3rtp_pkg::FT_FIRST_MAJOR ||
                     ftype == ac3rtp_pkg::FT_FIRST_MINOR)
        |-> !m_tlast && foffset == '0 && fcount > 7'd1)
        else $error("bad first fragment");

    // Continuation fragment lies past the start of the frame
    a_cont: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ftype == ac3rtp_pkg::FT_CONT |-> foffset != '0 && fcount > 7'd1)
        else $error("bad continuation fragment");

endmodule

bind ac3_rtp_fragmenter ac3rtp_checker u_ac3rtp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

[tb/tb_top.sv]
// Self-checking testbench for the AC-3 RTP fragmenter: predicted vs. streamed descriptors.
module tb_top;

    localparam int LEN_W    = ac3rtp_pkg::LEN_W;
    localparam int TS_W     = ac3rtp_pkg::TS_W;
    localparam int MTU_W    = ac3rtp_pkg::MTU_W;
    localparam int CNT_W    = ac3rtp_pkg::CNT_W;
    localparam int TYPE_W   = ac3rtp_pkg::TYPE_W;
    localparam int S_DATA_W = ac3rtp_pkg::S_DATA_W;
    localparam int M_DATA_W = ac3rtp_pkg::M_DATA_W;

    localparam int MAX_FRAGS   = 64;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 300;
    localparam int PHASE_ITEMS = 24;
    localparam int MTU_HOLD    = 10;
    localparam int N_ROWS      = 23;

    // One expected packet descriptor
    typedef struct packed {
        logic [TYPE_W-1:0] ftype;
        logic [CNT_W-1:0]  count;
        logic [LEN_W-1:0]  offset;
        logic [LEN_W-1:0]  nbytes;
        logic [TS_W-1:0]   stamp;
        logic              fin;
    } pkt_desc_t;

    // One directed frame; typed rows also fix the lead type and the packet count
    typedef struct packed {
        logic [MTU_W-1:0]  mtu;
        logic [LEN_W-1:0]  len;
        logic [TS_W-1:0]   stamp;
        logic              typed;
        logic [TYPE_W-1:0] ftype;
        logic [CNT_W-1:0]  count;
    } frame_row_t;

    frame_row_t frame_rows [N_ROWS] = '{
        // reset MTU: empty frame, exact fit, one byte over, longest frame
        '{14'd1436,  13'd0,    32'h0000_0000, 1'b1, ac3rtp_pkg::FT_WHOLE,       7'd1},
        '{14'd1436,  13'd1434, 32'hFFFF_FFFF, 1'b1, ac3rtp_pkg::FT_WHOLE,       7'd1},
        '{14'd1436,  13'd1435, 32'h1234_5678, 1'b1, ac3rtp_pkg::FT_FIRST_MAJOR, 7'd2},
        '{14'd1436,  13'd8191, 32'h0000_0001, 1'b1, ac3rtp_pkg::FT_FIRST_MINOR, 7'd6},
        // room 1600: exactly five eighths, one byte past it, exact multiple
        '{14'd1602,  13'd2560, 32'hA5A5_A5A5, 1'b1, ac3rtp_pkg::FT_FIRST_MAJOR, 7'd2},
        '{14'd1602,  13'd2561, 32'h5A5A_5A5A, 1'b1, ac3rtp_pkg::FT_FIRST_MINOR, 7'd2},
        '{14'd1602,  13'd4800, 32'h8000_0000, 1'b1, ac3rtp_pkg::FT_FIRST_MINOR, 7'd3},
        // MTU below range saturates to the smallest room; then MTUs at the bottom of the range
        '{14'd0,     13'd8191, 32'h7FFF_FFFF, 1'b1, ac3rtp_pkg::FT_FIRST_MINOR, 7'd64},
        '{14'd0,     13'd128,  32'hDEAD_BEEF, 1'b1, ac3rtp_pkg::FT_WHOLE,       7'd1},
        '{14'd0,     13'd129,  32'h0F0F_0F0F, 1'b1, ac3rtp_pkg::FT_FIRST_MAJOR, 7'd2},
        '{14'd129,   13'd200,  32'hF0F0_F0F0, 1'b1, ac3rtp_pkg::FT_FIRST_MAJOR, 7'd2},
        '{14'd130,   13'd8191, 32'h0000_FFFF, 1'b1, ac3rtp_pkg::FT_FIRST_MINOR, 7'd64},
        '{14'd130,   13'd8064, 32'hFFFF_0000, 1'b1, ac3rtp_pkg::FT_FIRST_MINOR, 7'd63},
        '{14'd131,   13'd8191, 32'h0000_0002, 1'b1, ac3rtp_pkg::FT_FIRST_MINOR, 7'd64},
        // largest MTU and above range
        '{14'd9216,  13'd8191, 32'hCAFE_F00D, 1'b1, ac3rtp_pkg::FT_WHOLE,       7'd1},
        '{14'd9216,  13'd0,    32'hFFFF_FFFF, 1'b1, ac3rtp_pkg::FT_WHOLE,       7'd1},
        '{14'd9217,  13'd8191, 32'h1357_9BDF, 1'b1, ac3rtp_pkg::FT_WHOLE,       7'd1},
        '{14'd16383, 13'd8191, 32'h2468_ACE0, 1'b1, ac3rtp_pkg::FT_WHOLE,       7'd1},
        '{14'd16383, 13'd4096, 32'h0000_0000, 1'b1, ac3rtp_pkg::FT_WHOLE,       7'd1},
        // mid-range MTU, left to the predictor but for the last row
        '{14'd1000,  13'd5000, 32'h3141_5926, 1'b0, ac3rtp_pkg::FT_WHOLE,       7'd0},
        '{14'd1000,  13'd2000, 32'h2718_2818, 1'b0, ac3rtp_pkg::FT_WHOLE,       7'd0},
        '{14'd1436,  13'd2295, 32'h1618_0339, 1'b0, ac3rtp_pkg::FT_WHOLE,       7'd0},
        '{14'd1436,  13'd2294, 32'h1414_2135, 1'b1, ac3rtp_pkg::FT_FIRST_MAJOR, 7'd2}
    };

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [MTU_W-1:0]    cfg_data  = '0;

    pkt_desc_t           pkt_q [$];
    pkt_desc_t           want;
    logic [MTU_W-1:0]    mtu_shadow     = ac3rtp_pkg::MTU_RESET;
    int                  err_count      = 0;
    int                  src_idle_pct   = 0;
    int                  sink_stall_pct = 0;
    int unsigned         cycle_count    = 0;

    always #2 clk = ~clk;

    ac3_rtp_fragmenter #(
        .MAX_FRAGMENTS(MAX_FRAGS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Print one mismatch and count it
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, field, got, exp_val);
        err_count++;
    endtask

    // Payload bytes per packet after MTU saturation and the fragment-limit floor
    function automatic int unsigned payload_room(input logic [MTU_W-1:0] mtu);
        int unsigned lim;
        int unsigned floor_room;
        int unsigned room;
        lim = 32'(mtu);
        if (lim < 32'(ac3rtp_pkg::MTU_MIN))
            lim = 32'(ac3rtp_pkg::MTU_MIN);
        if (lim > 32'(ac3rtp_pkg::MTU_MAX))
            lim = 32'(ac3rtp_pkg::MTU_MAX);
        floor_room = unsigned'((ac3rtp_pkg::LEN_MAX + MAX_FRAGS - 1) / MAX_FRAGS);
        room = lim - 32'(ac3rtp_pkg::HDR_BYTES);
        if (room < floor_room)
            room = floor_room;
        return room;
    endfunction

    // Cut one frame into packet descriptors and queue them
    function automatic void queue_packets(input logic [LEN_W-1:0] len,
                                          input logic [TS_W-1:0] stamp,
                                          input logic typed,
                                          input logic [TYPE_W-1:0] typed_ftype,
                                          input logic [CNT_W-1:0] typed_count);
        int unsigned room;
        int unsigned n;
        int unsigned rest;
        int unsigned off;
        int unsigned chunk;
        int unsigned i;
        logic [TYPE_W-1:0] lead;
        pkt_desc_t d;
        room = payload_room(mtu_shadow);
        rest = 32'(len);
        if (rest <= room)
        begin
            n    = 1;
            lead = ac3rtp_pkg::FT_WHOLE;
        end
        else
        begin
            n    = (rest + room - 1) / room;
            lead = (5 * rest <= 8 * room) ? ac3rtp_pkg::FT_FIRST_MAJOR
                                          : ac3rtp_pkg::FT_FIRST_MINOR;
        end
        if (typed)
        begin
            n    = 32'(typed_count);
            lead = typed_ftype;
        end
        off = 0;
        for (i = 0; i < n; i++)
        begin
            chunk    = (rest > room) ? room : rest;
            d.ftype  = (i == 0) ? lead : ac3rtp_pkg::FT_CONT;
            d.count  = CNT_W'(n);
            d.offset = LEN_W'(off);
            d.nbytes = LEN_W'(chunk);
            d.stamp  = stamp;
            d.fin    = (i + 1 == n);
            pkt_q.push_back(d);
            off  += chunk;
            rest -= chunk;
        end
    endfunction

    // Offer one frame, with random idle cycles ahead of it, and predict on acceptance
    task automatic push_frame(input logic [LEN_W-1:0] len, input logic [TS_W-1:0] stamp,
                              input logic typed, input logic [TYPE_W-1:0] typed_ftype,
                              input logic [CNT_W-1:0] typed_count);
        while ($urandom_range(99, 0) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - LEN_W - TS_W){1'b0}}, stamp, len};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        queue_packets(len, stamp, typed, typed_ftype, typed_count);
    endtask

    // Stop offering frames and wait for every pending packet
    task automatic drain_output();
        s_tvalid <= 1'b0;
        while (pkt_q.size() != 0)
            @(posedge clk);
    endtask

    // Write the MTU register through the config channel
    task automatic write_mtu(input logic [MTU_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        mtu_shadow = value;
    endtask

    // Stall the output side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99, 0) >= sink_stall_pct);
    end

    // Compare each output transaction with the oldest pending descriptor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pkt_q.size() == 0)
                report_mismatch("packet with nothing pending", 32'(m_tdata[34:22]), 32'd0);
            else
            begin
                want = pkt_q.pop_front();
                if (m_tdata[1:0] != want.ftype)
                    report_mismatch("frame_type", 32'(m_tdata[1:0]), 32'(want.ftype));
                if (m_tdata[8:2] != want.count)
                    report_mismatch("fragment_count", 32'(m_tdata[8:2]), 32'(want.count));
                if (m_tdata[21:9] != want.offset)
                    report_mismatch("payload_offset", 32'(m_tdata[21:9]), 32'(want.offset));
                if (m_tdata[34:22] != want.nbytes)
                    report_mismatch("payload_length", 32'(m_tdata[34:22]),
                                    32'(want.nbytes));
                if (m_tdata[66:35] != want.stamp)
                    report_mismatch("packet_timestamp", m_tdata[66:35], want.stamp);
                if (m_tlast != want.fin)
                    report_mismatch("last", 32'(m_tlast), 32'(want.fin));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int r;
        int ph;
        int k;
        int unsigned room;
        int unsigned v;
        logic [MTU_W-1:0] mtu;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames, MTU rewritten only when idle
        for (r = 0; r < N_ROWS; r++)
        begin
            if (frame_rows[r].mtu != mtu_shadow)
            begin
                drain_output();
                write_mtu(frame_rows[r].mtu);
            end
            push_frame(frame_rows[r].len, frame_rows[r].stamp, frame_rows[r].typed,
                       frame_rows[r].ftype, frame_rows[r].count);
        end

        // Random frames under four idle/stall mixes
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 83;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 83;
                end
                default:
                begin
                    src_idle_pct   = 25;
                    sink_stall_pct = 25;
                end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k % MTU_HOLD == 0)
                begin
                    drain_output();
                    case ($urandom_range(9, 0))
                        0:       mtu = MTU_W'($urandom_range(ac3rtp_pkg::MTU_MIN - 1, 0));
                        1:       mtu = MTU_W'($urandom_range(16383, ac3rtp_pkg::MTU_MAX + 1));
                        2, 3, 4: mtu = MTU_W'($urandom_range(400, ac3rtp_pkg::MTU_MIN));
                        default: mtu = MTU_W'($urandom_range(ac3rtp_pkg::MTU_MAX,
                                                             ac3rtp_pkg::MTU_MIN));
                    endcase
                    write_mtu(mtu);
                end
                room = payload_room(mtu_shadow);
                // Favor lengths around fragment edges and the five-eighths split
                case ($urandom_range(7, 0))
                    1:       v = $urandom_range(3, 0);
                    2:       v = ac3rtp_pkg::LEN_MAX;
                    3:       v = room * $urandom_range(64, 1) + $urandom_range(2, 0) - 1;
                    4:       v = (8 * room) / 5 + $urandom_range(2, 0) - 1;
                    5:       v = $urandom_range((room < ac3rtp_pkg::LEN_MAX) ? room
                                                : ac3rtp_pkg::LEN_MAX, 0);
                    default: v = $urandom_range(ac3rtp_pkg::LEN_MAX, 0);
                endcase
                if (v > ac3rtp_pkg::LEN_MAX)
                    v = ac3rtp_pkg::LEN_MAX;
                push_frame(LEN_W'(v), $urandom, 1'b0, ac3rtp_pkg::FT_WHOLE, '0);
            end
        end

        // Drain, then watch for stray packets
        drain_output();
        sink_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
design/ac3rtp_pkg.sv
design/ac3_rtp_fragmenter.sv
design/ac3rtp_checker.sv
tb/tb_top.sv
